/* src/hcm_pkg.sv */
// Package for the iteration count hue colormap.
// Holds widths, reset value, sector codes and the tag word carried down the cell chain.
// No dependencies.
package hcm_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int FIELD_WIDTH         = 16;
   localparam int CHAN_WIDTH          = 8;
   localparam int SEC_BITS            = 3;
   localparam int SECTOR_STEPS        = 3;
   localparam int RAMP_STEPS          = 8;

   localparam logic [FIELD_WIDTH-1:0] MAX_ITER_RESET = 16'd256;
   localparam logic [CHAN_WIDTH-1:0]  CHAN_FULL      = 8'hFF;
   localparam logic [CHAN_WIDTH-1:0]  CHAN_ZERO      = 8'h00;

   localparam logic [SEC_BITS-1:0] SEC_RED_GREEN_UP    = 3'd0;
   localparam logic [SEC_BITS-1:0] SEC_GREEN_RED_DOWN  = 3'd1;
   localparam logic [SEC_BITS-1:0] SEC_GREEN_BLUE_UP   = 3'd2;
   localparam logic [SEC_BITS-1:0] SEC_BLUE_GREEN_DOWN = 3'd3;
   localparam logic [SEC_BITS-1:0] SEC_BLUE_RED_UP     = 3'd4;

   typedef struct packed {
      logic                  blk;
      logic [SEC_BITS-1:0]   sec;
      logic [CHAN_WIDTH-1:0] quo;
   } hcm_tag_type;

endpackage

/* src/hcm_cell.sv */
// One restoring divide step of the colormap cell chain.
// Compares the partial remainder with the shifted limit and sets one quotient bit.
// Depends on hcm_pkg.
module hcm_cell
   import hcm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int RW          = COUNT_WIDTH_DEFAULT + CHAN_WIDTH,
   parameter int SHIFT       = 0,
   parameter bit IS_SECTOR   = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COUNT_WIDTH-1:0] lim,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [RW-1:0]          in_rem,
   input  hcm_tag_type            in_tag,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [RW-1:0]          out_rem,
   output hcm_tag_type            out_tag
);

   localparam logic [CHAN_WIDTH-1:0] BIT_MASK = CHAN_WIDTH'(1) << SHIFT;

   logic              v_ff, v_in;
   logic [RW-1:0]     rem_ff, rem_in;
   hcm_tag_type       tag_ff, tag_in;
   logic [RW-1:0]     div_sh;
   logic              take;

   assign div_sh   = RW'(lim) << SHIFT;
   assign take     = in_rem >= div_sh;
   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_comb begin
      tag_in = in_tag;
      rem_in = in_rem;
      if (take) begin
         rem_in = in_rem - div_sh;
         if (IS_SECTOR) begin
            tag_in.sec = in_tag.sec | BIT_MASK[SEC_BITS-1:0];
         end else begin
            tag_in.quo = in_tag.quo | BIT_MASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_tag   = tag_ff;

endmodule

/* src/hcm_prep.sv */
// Ramp numerator stage of the colormap cell chain.
// Folds the remainder for odd sectors and forms 255 times it for the ramp division.
// Depends on hcm_pkg.
module hcm_prep
   import hcm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int RW          = COUNT_WIDTH_DEFAULT + CHAN_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COUNT_WIDTH-1:0] lim,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [RW-1:0]          in_rem,
   input  hcm_tag_type            in_tag,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [RW-1:0]          out_rem,
   output hcm_tag_type            out_tag
);

   logic                   v_ff, v_in;
   logic [RW-1:0]          rem_ff, rem_in;
   hcm_tag_type            tag_ff, tag_in;
   logic [COUNT_WIDTH-1:0] fold;

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;
   assign fold     = in_tag.sec[0] ? (lim - in_rem[COUNT_WIDTH-1:0]) : in_rem[COUNT_WIDTH-1:0];
   assign rem_in   = (RW'(fold) << CHAN_WIDTH) - RW'(fold);

   always_comb begin
      tag_in     = in_tag;
      tag_in.quo = CHAN_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_tag   = tag_ff;

endmodule

/* src/hcm_out.sv */
// Output stage of the colormap: places the ramp by sector and holds the result word.
// Depends on hcm_pkg.
module hcm_out
   import hcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hcm_tag_type           in_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_WIDTH-1:0] rsp_red,
   output logic [CHAN_WIDTH-1:0] rsp_green,
   output logic [CHAN_WIDTH-1:0] rsp_blue
);

   logic                  v_ff, v_in;
   logic [CHAN_WIDTH-1:0] red_ff, red_in;
   logic [CHAN_WIDTH-1:0] green_ff, green_in;
   logic [CHAN_WIDTH-1:0] blue_ff, blue_in;

   assign in_ready = !v_ff || rsp_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_comb begin
      red_in   = CHAN_FULL;
      green_in = CHAN_ZERO;
      blue_in  = in_tag.quo;
      unique case (in_tag.sec)
         SEC_RED_GREEN_UP: begin
            red_in = CHAN_FULL; green_in = in_tag.quo; blue_in = CHAN_ZERO;
         end
         SEC_GREEN_RED_DOWN: begin
            red_in = in_tag.quo; green_in = CHAN_FULL; blue_in = CHAN_ZERO;
         end
         SEC_GREEN_BLUE_UP: begin
            red_in = CHAN_ZERO; green_in = CHAN_FULL; blue_in = in_tag.quo;
         end
         SEC_BLUE_GREEN_DOWN: begin
            red_in = CHAN_ZERO; green_in = in_tag.quo; blue_in = CHAN_FULL;
         end
         SEC_BLUE_RED_UP: begin
            red_in = in_tag.quo; green_in = CHAN_ZERO; blue_in = CHAN_FULL;
         end
         default: begin
            red_in = CHAN_FULL; green_in = CHAN_ZERO; blue_in = in_tag.quo;
         end
      endcase
      if (in_tag.blk) begin
         red_in   = CHAN_ZERO;
         green_in = CHAN_ZERO;
         blue_in  = CHAN_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

/* src/iteration_count_hue_colormap_top.sv */
// Iteration count hue colormap, top level.
// Chains divide-step cells, the ramp numerator stage and the output stage; uses hcm_pkg.
//
// Usage:
//   req channel: one 16-bit escape count per word, valid/ready.
//   rsp channel: one RGB pixel (8 bits per channel) per word, valid/ready.
//   csr port: csr_write_enable with csr_write_data loads the iteration limit;
//     write it only while no word is in flight.
// Pipeline: a word accepted on req passes through three sector divide cells,
//   one numerator stage, eight ramp divide cells and one output register
//   before it is shown on rsp.
// Throughput: one word per cycle unless rsp stalls; every stage holds its own valid bit.
// Stall: a stalled receiver holds the output word; stages upstream keep
//   filling empty slots, so up to 13 words can be taken before req_ready drops.
// Reset: clears all valid bits and loads the limit with 256 (masked to
//   COUNT_WIDTH bits).
// Counts at or above the limit, and any count when the limit is zero, give black.
module iteration_count_hue_colormap_top
   import hcm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_WIDTH-1:0] req_iteration_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAN_WIDTH-1:0]  rsp_red,
   output logic [CHAN_WIDTH-1:0]  rsp_green,
   output logic [CHAN_WIDTH-1:0]  rsp_blue,
   input  logic                   csr_write_enable,
   input  logic [FIELD_WIDTH-1:0] csr_write_data
);

   localparam int RW = COUNT_WIDTH + CHAN_WIDTH;

   logic [COUNT_WIDTH-1:0] lim_ff, lim_in;
   logic [FIELD_WIDTH+COUNT_WIDTH-1:0] cnt_wide, wdata_wide, reset_wide;
   logic [COUNT_WIDTH-1:0] cnt;

   logic              s_valid [0:SECTOR_STEPS];
   logic              s_ready [0:SECTOR_STEPS];
   logic [RW-1:0]     s_rem   [0:SECTOR_STEPS];
   hcm_tag_type       s_tag   [0:SECTOR_STEPS];

   logic              r_valid [0:RAMP_STEPS];
   logic              r_ready [0:RAMP_STEPS];
   logic [RW-1:0]     r_rem   [0:RAMP_STEPS];
   hcm_tag_type       r_tag   [0:RAMP_STEPS];

   assign cnt_wide   = {{COUNT_WIDTH{1'b0}}, req_iteration_count};
   assign wdata_wide = {{COUNT_WIDTH{1'b0}}, csr_write_data};
   assign reset_wide = {{COUNT_WIDTH{1'b0}}, MAX_ITER_RESET};
   assign cnt        = cnt_wide[COUNT_WIDTH-1:0];
   assign lim_in     = csr_write_enable ? wdata_wide[COUNT_WIDTH-1:0] : lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= reset_wide[COUNT_WIDTH-1:0];
      end else begin
         lim_ff <= lim_in;
      end
   end

   // seed the chain with 6 * count
   assign s_valid[0]   = req_valid;
   assign req_ready    = s_ready[0];
   assign s_rem[0]     = (RW'(cnt) << 2) + (RW'(cnt) << 1);
   assign s_tag[0].blk = cnt >= lim_ff;
   assign s_tag[0].sec = '0;
   assign s_tag[0].quo = CHAN_ZERO;

   for (genvar i = 0; i < SECTOR_STEPS; i++) begin : g_sector
      hcm_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .RW          (RW),
         .SHIFT       (SECTOR_STEPS - 1 - i),
         .IS_SECTOR   (1'b1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .lim       (lim_ff),
         .in_valid  (s_valid[i]),
         .in_ready  (s_ready[i]),
         .in_rem    (s_rem[i]),
         .in_tag    (s_tag[i]),
         .out_valid (s_valid[i+1]),
         .out_ready (s_ready[i+1]),
         .out_rem   (s_rem[i+1]),
         .out_tag   (s_tag[i+1])
      );
   end

   hcm_prep #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .RW          (RW)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .lim       (lim_ff),
      .in_valid  (s_valid[SECTOR_STEPS]),
      .in_ready  (s_ready[SECTOR_STEPS]),
      .in_rem    (s_rem[SECTOR_STEPS]),
      .in_tag    (s_tag[SECTOR_STEPS]),
      .out_valid (r_valid[0]),
      .out_ready (r_ready[0]),
      .out_rem   (r_rem[0]),
      .out_tag   (r_tag[0])
   );

   for (genvar j = 0; j < RAMP_STEPS; j++) begin : g_ramp
      hcm_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .RW          (RW),
         .SHIFT       (RAMP_STEPS - 1 - j),
         .IS_SECTOR   (1'b0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .lim       (lim_ff),
         .in_valid  (r_valid[j]),
         .in_ready  (r_ready[j]),
         .in_rem    (r_rem[j]),
         .in_tag    (r_tag[j]),
         .out_valid (r_valid[j+1]),
         .out_ready (r_ready[j+1]),
         .out_rem   (r_rem[j+1]),
         .out_tag   (r_tag[j+1])
      );
   end

   hcm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid[RAMP_STEPS]),
      .in_ready  (r_ready[RAMP_STEPS]),
      .in_tag    (r_tag[RAMP_STEPS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_sector_in_range : assert property (@(posedge clock) disable iff (reset)
      (s_valid[SECTOR_STEPS] && !s_tag[SECTOR_STEPS].blk)
         |-> (s_tag[SECTOR_STEPS].sec <= SEC_BLUE_RED_UP + 3'd1))
      else $error("hue sector out of range");

   a_sector_rem_below_limit : assert property (@(posedge clock) disable iff (reset)
      (s_valid[SECTOR_STEPS] && !s_tag[SECTOR_STEPS].blk)
         |-> (s_rem[SECTOR_STEPS] < RW'(lim_ff)))
      else $error("sector remainder not below limit");

   a_pixel_on_wheel : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red == CHAN_ZERO && rsp_green == CHAN_ZERO && rsp_blue == CHAN_ZERO)
         || ((rsp_red == CHAN_FULL || rsp_green == CHAN_FULL || rsp_blue == CHAN_FULL)
            && (rsp_red == CHAN_ZERO || rsp_green == CHAN_ZERO || rsp_blue == CHAN_ZERO))))
      else $error("pixel is neither black nor fully saturated");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for iteration_count_hue_colormap_top: drives escape counts and limit writes,
// predicts each RGB pixel on the hue wheel and checks results in order. Uses hcm_pkg.
module tb;
   import hcm_pkg::*;

   localparam int          COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int          FLUSH_CYCLES = 16;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } pixel_type;

   class scoreboard_type;
      pixel_type   pending[$];
      logic [15:0] limit;
      int unsigned errors;

      function new();
         limit  = 16'(MAX_ITER_RESET & width_mask());
         errors = 0;
      endfunction

      function int unsigned width_mask();
         longint unsigned m;
         m = (64'd1 << COUNT_WIDTH) - 64'd1;
         return m[31:0];
      endfunction

      function void set_limit(logic [15:0] value);
         limit = 16'(value & width_mask());
      endfunction

      function pixel_type hue_of(logic [15:0] count);
         pixel_type   px;
         int unsigned c, lim, t, sector, rem, ramp;
         px  = '0;
         c   = count & width_mask();
         lim = 32'(limit);
         if (lim != 0 && c < lim) begin
            t      = 6 * c;
            sector = t / lim;
            rem    = t % lim;
            if (sector[0] == 1'b0) ramp = (255 * rem) / lim;
            else ramp = (255 * (lim - rem)) / lim;
            case (sector)
               SEC_RED_GREEN_UP:    px = '{CHAN_FULL, ramp[7:0], CHAN_ZERO};
               SEC_GREEN_RED_DOWN:  px = '{ramp[7:0], CHAN_FULL, CHAN_ZERO};
               SEC_GREEN_BLUE_UP:   px = '{CHAN_ZERO, CHAN_FULL, ramp[7:0]};
               SEC_BLUE_GREEN_DOWN: px = '{CHAN_ZERO, ramp[7:0], CHAN_FULL};
               SEC_BLUE_RED_UP:     px = '{ramp[7:0], CHAN_ZERO, CHAN_FULL};
               default:             px = '{CHAN_FULL, CHAN_ZERO, ramp[7:0]};
            endcase
         end
         return px;
      endfunction

      function void note_count(logic [15:0] count);
         pending.push_back(hue_of(count));
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected pixel %h/%h/%h", got.red, got.green, got.blue);
            return;
         end
         want = pending.pop_front();
         if (want != got) begin
            errors++;
            if (errors <= 10)
               $display("pixel mismatch: expected %h/%h/%h, got %h/%h/%h",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FIELD_WIDTH-1:0] req_iteration_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAN_WIDTH-1:0]  rsp_red, rsp_green, rsp_blue;
   logic                   csr_write_enable = 1'b0;
   logic [FIELD_WIDTH-1:0] csr_write_data = '0;

   logic                   calm = 1'b0;
   int unsigned            cycles = 0;
   scoreboard_type         sb = new();

   iteration_count_hue_colormap_top #(.COUNT_WIDTH(COUNT_WIDTH)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_iteration_count (req_iteration_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_pixel('{rsp_red, rsp_green, rsp_blue});
      rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
   end

   task automatic send_word(input logic [15:0] count);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_iteration_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_count(count);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_limit(value);
   endtask

   function automatic logic [15:0] pick_count(input logic [15:0] lim);
      int unsigned sel, k, c;
      sel = $urandom_range(0, 99);
      if (lim == 0 || sel < 10) return 16'($urandom);
      if (sel < 20) return 16'($urandom_range(lim, 65535));
      if (sel < 35) begin
         k = $urandom_range(1, 5);
         c = (k * lim + 5) / 6 - $urandom_range(0, 1);
         return 16'(c);
      end
      return 16'($urandom_range(0, lim - 1));
   endfunction

   initial begin
      logic [15:0] limits[10];
      logic [15:0] lim;
      int unsigned b;
      limits = '{16'hFFFF, 16'd1, 16'd6, 16'd7, 16'd0, 16'($urandom), 16'd5,
                 16'($urandom_range(1000, 65535)), 16'd256,
                 16'($urandom_range(2, 60))};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hue wheel at the reset limit: ends, sector edges, in-set edge
      lim = sb.limit;
      send_word(16'd0);
      send_word(16'd1);
      for (int k = 1; k <= 5; k++) begin
         b = (k * lim + 5) / 6;
         send_word(16'(b - 1));
         send_word(16'(b));
      end
      send_word(lim - 16'd1);
      send_word(lim);
      send_word(lim + 16'd1);
      send_word(16'hFFFF);
      send_word(16'h5555);
      send_word(16'hAAAA);

      for (int p = 0; p < 10; p++) begin
         write_limit(limits[p]);
         calm = (p == 2);
         for (int i = 0; i < 45; i++) begin
            if (p == 5 && i == 22) drain();
            send_word(pick_count(sb.limit));
         end
      end
      calm = 1'b0;

      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (sb.pending.size() != 0) sb.errors++;
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
